// ----- rtl/dss_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Disk sweep seek scheduler package
// Shared input kind codes and output field widths.
// ----------------------------------------------------------------------------
package dss_pkg;
    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_START = 1'b1;
    localparam int   CYL_BITS   = 16;
    localparam int   SEEK_BITS  = 17;
    localparam int   TOTAL_BITS = 22;
    localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = {TOTAL_BITS{1'b1}};
endpackage

// ----- rtl/dss_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module dss_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- rtl/disk_sweep_seek_scheduler.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Disk sweep seek scheduler
// Sorted request store with LOOK sweep and circular service order.
// ----------------------------------------------------------------------------
// Usage: a slave transfer with kind load (tuser 0) inserts the cylinder in
// tdata into an ascending store held in one synchronous RAM. Insertion walks
// down from the top, one read-compare-shift step per entry above the new
// value, writing it where the walk stops. Loads into a full store are
// dropped. A start transfer (tuser 1) gives the head position. The block
// searches the RAM for the first request at or above the head, one read
// and compare per entry, then emits one move per stored request on the
// master side: from, to, seek and a saturating running total, tlast on the
// final move. Each move needs a RAM read (S_MV_RD), a compute step
// (S_MV_CALC) and the output register (S_OUT); the next move is read only
// after the receiver has taken the previous one. An empty store yields one zero move.
// The circular wrap move charges the distance to the lowest request plus the
// span of the store. The result sits in an output register; a stalled
// receiver holds the block in place with tdata stable. Reset clears the
// count, mode and control; RAM contents are not cleared and stay until they
// are overwritten. Requests are kept across starts.
// ----------------------------------------------------------------------------
module disk_sweep_seek_scheduler #(
    parameter int QUEUE_DEPTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_data,        // sweep_mode
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,      // cylinder
    input  logic        s_axis_tuser,      // kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,      // from_cyl, to_cyl, seek, total_seek, pad
    output logic        m_axis_tlast       // last
);
    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int RD = 1 << AW;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int SB = dss_pkg::SEEK_BITS;
    localparam int TB = dss_pkg::TOTAL_BITS;

    typedef enum logic [3:0] {
        S_IDLE, S_INS_RD, S_INS_CMP, S_SRCH_RD, S_SRCH_CMP,
        S_MAX_RD, S_MAX_WT, S_MV_RD, S_MV_CALC, S_OUT
    } t_state;

    // Service phases of one schedule.
    typedef enum logic [1:0] {P_UP, P_DOWN, P_WRAP, P_CIRC} t_phase;

    t_state          r_state;
    t_phase          r_phase;
    logic            r_mode;
    logic [CW-1:0]   r_count;
    logic [CW-1:0]   r_pos;     // insert position or current index
    logic [CW-1:0]   r_idx;     // first index at or above head
    logic [15:0]     r_cyl;     // value being inserted or head
    logic [15:0]     r_cur;
    logic [15:0]     r_max;
    logic [TB-1:0]   r_total;
    logic            r_wrap;    // next move is the circular jump
    logic [15:0]     r_from, r_to;
    logic [SB-1:0]   r_seek;
    logic            r_last;

    logic            w_we;
    logic [AW-1:0]   w_waddr, w_raddr;
    logic [15:0]     w_wdata, w_rdata;
    logic [15:0]     w_in_cyl;

    assign w_in_cyl = s_axis_tdata & 16'((64'(1) << dss_pkg::CYL_BITS) - 64'(1));

    dss_ram #(.WIDTH(16), .DEPTH(RD)) u_ram (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(w_wdata),
        .i_raddr(w_raddr), .o_rdata(w_rdata)
    );

    // Read address follows the state that issues the read.
    always_comb begin
        w_raddr = '0;
        if (r_state == S_INS_RD) begin
            w_raddr = AW'(r_pos - CW'(1));
        end else if (r_state == S_MAX_RD) begin
            w_raddr = AW'(r_count - CW'(1));
        end else begin
            w_raddr = AW'(r_pos);
        end
    end

    // Insertion writes: shift up an entry, or drop the new value in place.
    // At position zero no entry lies below, so the new value always lands there.
    logic w_shift;
    assign w_shift = (r_state == S_INS_CMP) && (r_pos != '0) && (w_rdata > r_cyl);
    assign w_we    = (r_state == S_INS_CMP);
    assign w_waddr = AW'(r_pos);
    assign w_wdata = w_shift ? w_rdata : r_cyl;

    // Move arithmetic for the entry just read.
    logic [15:0]     w_diff;
    logic [SB-1:0]   w_d;
    logic [TB:0]     w_sum;
    logic [TB-1:0]   w_tot;
    assign w_diff = (w_rdata > r_cur) ? (w_rdata - r_cur) : (r_cur - w_rdata);
    assign w_d    = r_wrap ? (SB'(w_diff) + SB'(r_max - w_rdata)) : SB'(w_diff);
    assign w_sum  = (TB+1)'(r_total) + (TB+1)'(w_d);
    assign w_tot  = (w_sum > (TB+1)'(dss_pkg::TOTAL_MAX)) ? dss_pkg::TOTAL_MAX
                                                           : TB'(w_sum);

    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready   = (r_state == S_IDLE);
    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tdata  = {1'b0, r_total, r_seek, r_to, r_from};
    assign m_axis_tlast  = r_last;

    // Control FSM: insertion, search, and per move which phase follows and whether the schedule is done after it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= P_UP;
            r_mode  <= 1'b0;
            r_count <= '0;
            r_wrap  <= 1'b0;
            r_last  <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_cfg_valid) begin
                        r_mode <= i_cfg_data;
                    end
                    if (s_axis_tvalid) begin
                        r_cyl <= w_in_cyl;
                        if (s_axis_tuser == dss_pkg::KIND_LOAD) begin
                            if (r_count < CW'(QUEUE_DEPTH)) begin
                                r_pos   <= r_count;
                                r_count <= r_count + CW'(1);
                                r_state <= (r_count == '0) ? S_INS_CMP : S_INS_RD;
                            end
                        end else if (r_count == '0) begin
                            r_from  <= w_in_cyl;
                            r_to    <= w_in_cyl;
                            r_seek  <= '0;
                            r_total <= '0;
                            r_last  <= 1'b1;
                            r_state <= S_OUT;
                        end else begin
                            r_pos   <= '0;
                            r_state <= S_SRCH_RD;
                        end
                    end
                end
                S_INS_RD: r_state <= S_INS_CMP;
                S_INS_CMP: begin
                    // With position zero the read data is stale; never shift there.
                    if (w_shift) begin
                        r_pos   <= r_pos - CW'(1);
                        r_state <= (r_pos == CW'(1)) ? S_INS_CMP : S_INS_RD;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_SRCH_RD: r_state <= S_SRCH_CMP;
                S_SRCH_CMP: begin
                    if (w_rdata < r_cyl && r_pos + CW'(1) < r_count) begin
                        r_pos   <= r_pos + CW'(1);
                        r_state <= S_SRCH_RD;
                    end else begin
                        if (w_rdata < r_cyl) begin
                            r_pos <= r_count;
                            r_idx <= r_count;
                        end else begin
                            r_idx <= r_pos;
                        end
                        r_state <= S_MAX_RD;
                    end
                end
                S_MAX_RD: r_state <= S_MAX_WT;
                S_MAX_WT: begin
                    r_max   <= w_rdata;
                    r_cur   <= r_cyl;
                    r_total <= '0;
                    r_state <= S_MV_RD;
                    if (r_pos < r_count) begin
                        r_phase <= P_UP;
                        r_wrap  <= 1'b0;
                    end else if (!r_mode) begin
                        r_phase <= P_DOWN;
                        r_wrap  <= 1'b0;
                        r_pos   <= r_count - CW'(1);
                    end else begin
                        r_phase <= P_CIRC;
                        r_wrap  <= 1'b1;
                        r_pos   <= '0;
                    end
                end
                S_MV_RD: r_state <= S_MV_CALC;
                S_MV_CALC: begin
                    r_from  <= r_cur;
                    r_to    <= w_rdata;
                    r_seek  <= w_d;
                    r_total <= w_tot;
                    r_cur   <= w_rdata;
                    case (r_phase)
                        P_UP: begin
                            if (r_pos + CW'(1) < r_count) begin
                                r_pos  <= r_pos + CW'(1);
                                r_wrap <= 1'b0;
                                r_last <= 1'b0;
                            end else if (r_idx == '0) begin
                                r_wrap <= 1'b0;
                                r_last <= 1'b1;
                            end else if (!r_mode) begin
                                r_phase <= P_DOWN;
                                r_pos   <= r_idx - CW'(1);
                                r_wrap  <= 1'b0;
                                r_last  <= 1'b0;
                            end else begin
                                r_phase <= P_CIRC;
                                r_wrap  <= 1'b1;
                                r_pos   <= '0;
                                r_last  <= 1'b0;
                            end
                        end
                        P_DOWN: begin
                            r_wrap <= 1'b0;
                            if (r_pos == '0) begin
                                r_last <= 1'b1;
                            end else begin
                                r_pos  <= r_pos - CW'(1);
                                r_last <= 1'b0;
                            end
                        end
                        default: begin
                            r_wrap <= 1'b0;
                            if (r_pos + CW'(1) < r_idx) begin
                                r_pos  <= r_pos + CW'(1);
                                r_last <= 1'b0;
                            end else begin
                                r_last <= 1'b1;
                            end
                        end
                    endcase
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (m_axis_tready) begin
                        r_state <= r_last ? S_IDLE : S_MV_RD;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
